// ===== rtl/core/descriptor_ring_recycler_core_assert.svh =====
// Assertion macros used by the descriptor ring recycler checker.
`ifndef DESCRIPTOR_RING_RECYCLER_CORE_ASSERT_SVH
`define DESCRIPTOR_RING_RECYCLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("descriptor ring recycler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("descriptor ring recycler check failed");

`endif

// ===== rtl/core/drr_pkg.sv =====
// Shared constants, codes and types of the descriptor ring recycler.
`default_nettype none

package drr_pkg;

    // Ring geometry and field widths.
    localparam int DEPTH_LOG2 = 10;
    localparam int CHANNELS   = 2;
    localparam int CH_W       = 1;
    localparam int ADDR_W     = CH_W + DEPTH_LOG2;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 16;
    localparam int TIME_W     = 64;
    localparam int HANDLE_W   = 32;
    localparam int CNT_W      = 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    typedef logic [DEPTH_LOG2-1:0] t_idx;
    typedef logic [ADDR_W-1:0]     t_addr;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SWAP  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_GET   = 2'd3;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TX_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RX_EMPTY   = 2'd3;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        OP_QUERY,
        OP_PUT,
        OP_SWAP,
        OP_GET,
        OP_IGNORE
    } t_op;

    // One queued command.
    typedef struct packed {
        t_op                 op;
        logic [CH_W-1:0]     channel;
        logic [LEN_W-1:0]    pkt_len;
        logic [TIME_W-1:0]   timestamp;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/drr_front.sv =====
// Front end: accepts input words and classifies them into commands.
`default_nettype none

module drr_front
    import drr_pkg::*;
(
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [LEN_W-1:0]    i_pkt_len,
    input  wire logic [TIME_W-1:0]   i_timestamp_us,
    input  wire logic [HANDLE_W-1:0] i_buffer_handle,
    input  wire logic                i_full,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    t_op op;

    // Decode the function code; a channel out of range is ignored.
    always_comb begin
        unique case (i_func)
            FN_QUERY: op = OP_QUERY;
            FN_PUT:   op = OP_PUT;
            FN_SWAP:  op = OP_SWAP;
            FN_GET:   op = OP_GET;
            default:  op = OP_QUERY;
        endcase
        if (int'(i_channel) >= CHANNELS) begin
            op = OP_IGNORE;
        end
    end

    // A word is taken whenever the command queue has room.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.op        = op;
        o_cmd.channel   = i_channel;
        o_cmd.pkt_len   = i_pkt_len;
        o_cmd.timestamp = i_timestamp_us;
        o_cmd.handle    = i_buffer_handle;
    end

endmodule

`default_nettype wire

// ===== rtl/core/drr_cmd_q.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module drr_cmd_q
    import drr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drr_back.sv =====
// Back end: ring pointers, ring and descriptor memories, sequencer and result register.
`default_nettype none

module drr_back
    import drr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire t_cmd                i_q_cmd,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [CNT_W-1:0]         o_rx_count,
    output logic                     o_head_valid,
    output logic [LEN_W-1:0]         o_head_len,
    output logic [TIME_W-1:0]        o_head_time,
    output logic [HANDLE_W-1:0]      o_head_handle,
    output logic                     o_got_valid,
    output logic [HANDLE_W-1:0]      o_got_handle
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OP   = 6'b000010,
        S_IDX  = 6'b000100,
        S_PEEK = 6'b001000,
        S_DESC = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    // Per-channel ring pointers and the free ring fill count.
    t_idx              r_free_head [CHANNELS];
    t_idx              r_free_tail [CHANNELS];
    t_idx              r_rx_head   [CHANNELS];
    t_idx              r_rx_tail   [CHANNELS];
    t_idx              r_tx_head   [CHANNELS];
    t_idx              r_tx_tail   [CHANNELS];
    logic [DEPTH_LOG2:0] r_free_fill [CHANNELS];

    // Memories and their registered read data.
    logic [LEN_W-1:0]    r_len_mem  [MEM_DEPTH];
    logic [TIME_W-1:0]   r_time_mem [MEM_DEPTH];
    logic [HANDLE_W-1:0] r_hdl_mem  [MEM_DEPTH];
    t_idx                r_free_mem [MEM_DEPTH];
    t_idx                r_rx_mem   [MEM_DEPTH];
    t_idx                r_tx_mem   [MEM_DEPTH];
    logic [LEN_W-1:0]    r_len_rd;
    logic [TIME_W-1:0]   r_time_rd;
    logic [HANDLE_W-1:0] r_hdl_rd;
    t_idx                r_free_rd;
    t_idx                r_rx_rd;
    t_idx                r_tx_rd;

    // Per-item working registers.
    logic                r_ok;
    logic [STATUS_W-1:0] r_status;
    logic                r_free_dflt;
    t_idx                r_free_pos;
    t_idx                r_rx_cnt;
    logic                r_head_valid;
    logic                r_got_valid;
    logic [HANDLE_W-1:0] r_got_handle;

    // Result register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]    r_out_rx_count;
    logic                r_out_head_valid;
    logic [LEN_W-1:0]    r_out_head_len;
    logic [TIME_W-1:0]   r_out_head_time;
    logic [HANDLE_W-1:0] r_out_head_handle;
    logic                r_out_got_valid;
    logic [HANDLE_W-1:0] r_out_got_handle;

    logic [CH_W-1:0]     ch;
    t_idx                free_cnt;
    t_idx                rx_cnt;
    t_idx                tx_cnt;
    t_idx                free_next_pos;
    logic                free_written;
    logic                op_ok;
    logic [STATUS_W-1:0] op_status;
    t_idx                idx;
    logic                out_load;
    logic                do_op;
    logic                do_idx;
    logic                do_peek;
    logic                do_desc;

    assign ch       = r_cmd.channel;
    assign free_cnt = r_free_head[ch] - r_free_tail[ch];
    assign rx_cnt   = r_rx_head[ch] - r_rx_tail[ch];
    assign tx_cnt   = r_tx_head[ch] - r_tx_tail[ch];

    // Slots whose next position is below the fill mark were rewritten; others hold their own position.
    assign free_next_pos = r_free_tail[ch] + 1'b1;
    assign free_written  = ({1'b0, free_next_pos} < r_free_fill[ch]);

    assign do_op   = (r_state == S_OP);
    assign do_idx  = (r_state == S_IDX);
    assign do_peek = (r_state == S_PEEK);
    assign do_desc = (r_state == S_DESC);

    assign out_load = !r_out_valid || i_ready;
    assign o_q_pop  = i_q_valid &&
                      ((r_state == S_IDLE) || ((r_state == S_OUT) && out_load));

    // Source ring check for the operation.
    always_comb begin
        op_ok     = 1'b0;
        op_status = ST_OK;
        unique case (r_cmd.op)
            OP_PUT: begin
                op_ok     = (free_cnt != '0);
                op_status = op_ok ? ST_OK : ST_POOL_EMPTY;
            end
            OP_SWAP: begin
                op_ok     = (rx_cnt != '0);
                op_status = op_ok ? ST_OK : ST_RX_EMPTY;
            end
            OP_GET: begin
                op_ok     = (tx_cnt != '0);
                op_status = op_ok ? ST_OK : ST_TX_EMPTY;
            end
            default: begin
                op_ok     = 1'b0;
                op_status = ST_OK;
            end
        endcase
    end

    // Descriptor index popped from the source ring.
    always_comb begin
        unique case (r_cmd.op)
            OP_PUT:  idx = r_free_dflt ? r_free_pos : r_free_rd;
            OP_SWAP: idx = r_rx_rd;
            OP_GET:  idx = r_tx_rd;
            default: idx = '0;
        endcase
    end

    // Sequencer: op check, index move when the check passes, peek of the rx ring, descriptor read, result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_OP;
                end
            end
            S_OP:   n_state = op_ok ? S_IDX : S_PEEK;
            S_IDX:  n_state = S_PEEK;
            S_PEEK: n_state = S_DESC;
            S_DESC: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = i_q_valid ? S_OP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_free_head[c] <= t_idx'(2 ** DEPTH_LOG2 - 1);
                r_free_tail[c] <= '0;
                r_rx_head[c]   <= '0;
                r_rx_tail[c]   <= '0;
                r_tx_head[c]   <= '0;
                r_tx_tail[c]   <= '0;
                r_free_fill[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Pop from the source ring.
            if (do_op && op_ok) begin
                unique case (r_cmd.op)
                    OP_PUT:  r_free_tail[ch] <= r_free_tail[ch] + 1'b1;
                    OP_SWAP: r_rx_tail[ch]   <= r_rx_tail[ch] + 1'b1;
                    OP_GET:  r_tx_tail[ch]   <= r_tx_tail[ch] + 1'b1;
                    default: ;
                endcase
            end

            // Push onto the destination ring.
            if (do_idx) begin
                unique case (r_cmd.op)
                    OP_PUT:  r_rx_head[ch] <= r_rx_head[ch] + 1'b1;
                    OP_SWAP: r_tx_head[ch] <= r_tx_head[ch] + 1'b1;
                    OP_GET: begin
                        r_free_head[ch] <= r_free_head[ch] + 1'b1;
                        if (r_free_fill[ch] != (DEPTH_LOG2+1)'(2 ** DEPTH_LOG2)) begin
                            r_free_fill[ch] <= r_free_fill[ch] + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // Result register handshake.
            if ((r_state == S_OUT) && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working data.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (do_op) begin
            r_ok        <= op_ok;
            r_status    <= op_status;
            r_free_dflt <= !free_written;
            r_free_pos  <= r_free_tail[ch];
        end
        if (do_peek) begin
            r_rx_cnt     <= (r_cmd.op == OP_IGNORE) ? '0 : rx_cnt;
            r_head_valid <= (r_cmd.op != OP_IGNORE) && (rx_cnt != '0);
            r_got_valid  <= r_ok && (r_cmd.op == OP_GET);
            r_got_handle <= r_hdl_rd;
        end
        if ((r_state == S_OUT) && out_load) begin
            r_out_status      <= r_status;
            r_out_rx_count    <= CNT_W'(r_rx_cnt);
            r_out_head_valid  <= r_head_valid;
            r_out_head_len    <= r_head_valid ? r_len_rd : '0;
            r_out_head_time   <= r_head_valid ? r_time_rd : '0;
            r_out_head_handle <= r_head_valid ? r_hdl_rd : '0;
            r_out_got_valid   <= r_got_valid;
            r_out_got_handle  <= r_got_valid ? r_got_handle : '0;
        end
    end

    // Free ring memory: read at the tail on a put, written at the head on a get.
    always_ff @(posedge i_clk) begin
        if (do_idx && (r_cmd.op == OP_GET)) begin
            r_free_mem[{ch, r_free_head[ch]}] <= idx;
        end
        if (do_op && (r_cmd.op == OP_PUT)) begin
            r_free_rd <= r_free_mem[{ch, r_free_tail[ch]}];
        end
    end

    // Rx ring memory: read at the tail for a swap and for the peek.
    always_ff @(posedge i_clk) begin
        if (do_idx && (r_cmd.op == OP_PUT)) begin
            r_rx_mem[{ch, r_rx_head[ch]}] <= idx;
        end
        if ((do_op && (r_cmd.op == OP_SWAP)) || do_peek) begin
            r_rx_rd <= r_rx_mem[{ch, r_rx_tail[ch]}];
        end
    end

    // Tx ring memory.
    always_ff @(posedge i_clk) begin
        if (do_idx && (r_cmd.op == OP_SWAP)) begin
            r_tx_mem[{ch, r_tx_head[ch]}] <= idx;
        end
        if (do_op && (r_cmd.op == OP_GET)) begin
            r_tx_rd <= r_tx_mem[{ch, r_tx_tail[ch]}];
        end
    end

    // Descriptor memories: filled by a put, read for a get and for the peek.
    always_ff @(posedge i_clk) begin
        if (do_idx && (r_cmd.op == OP_PUT)) begin
            r_len_mem[{ch, idx}]  <= r_cmd.pkt_len;
            r_time_mem[{ch, idx}] <= r_cmd.timestamp;
            r_hdl_mem[{ch, idx}]  <= r_cmd.handle;
        end
        if (do_desc) begin
            r_len_rd  <= r_len_mem[{ch, r_rx_rd}];
            r_time_rd <= r_time_mem[{ch, r_rx_rd}];
        end
        if (do_idx && (r_cmd.op == OP_GET)) begin
            r_hdl_rd <= r_hdl_mem[{ch, idx}];
        end else if (do_desc) begin
            r_hdl_rd <= r_hdl_mem[{ch, r_rx_rd}];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_rx_count    = r_out_rx_count;
    assign o_head_valid  = r_out_head_valid;
    assign o_head_len    = r_out_head_len;
    assign o_head_time   = r_out_head_time;
    assign o_head_handle = r_out_head_handle;
    assign o_got_valid   = r_out_got_valid;
    assign o_got_handle  = r_out_got_handle;

endmodule

`default_nettype wire

// ===== rtl/core/descriptor_ring_recycler_core.sv =====
// Top level of the descriptor ring recycler: front end, command queue and back end.
//
//   Channel  Direction  Handshake            Word
//   input    in         i_valid / o_ready    func, channel, pkt_len, timestamp_us, buffer_handle
//   result   out        o_valid / i_ready    status, rx_count, head_*, got_*
//
// A word steps through S_OP, S_IDX, S_PEEK, S_DESC and S_OUT in the back end when it moves a
// descriptor, and skips S_IDX when it does not; the chain of synchronous reads (ring index,
// descriptor, rx ring head, descriptor) sets these steps. The front end keeps accepting while
// the two-entry queue has room. Reset is synchronous; the free ring needs no clearing pass,
// since a per-channel fill count makes slots not yet rewritten read as their own position.
// A result waiting in the output register holds the back end only at its last step.
`default_nettype none

module descriptor_ring_recycler_core
    import drr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [CH_W-1:0]     i_channel,
    input  wire logic [LEN_W-1:0]    i_pkt_len,
    input  wire logic [TIME_W-1:0]   i_timestamp_us,
    input  wire logic [HANDLE_W-1:0] i_buffer_handle,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [CNT_W-1:0]         o_rx_count,
    output logic                     o_head_valid,
    output logic [LEN_W-1:0]         o_head_len,
    output logic [TIME_W-1:0]        o_head_time,
    output logic [HANDLE_W-1:0]      o_head_handle,
    output logic                     o_got_valid,
    output logic [HANDLE_W-1:0]      o_got_handle
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Accept and classify.
    drr_front u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_channel       (i_channel),
        .i_pkt_len       (i_pkt_len),
        .i_timestamp_us  (i_timestamp_us),
        .i_buffer_handle (i_buffer_handle),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_cmd           (front_cmd)
    );

    // Decoupling queue.
    drr_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Execute and report.
    drr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_rx_count    (o_rx_count),
        .o_head_valid  (o_head_valid),
        .o_head_len    (o_head_len),
        .o_head_time   (o_head_time),
        .o_head_handle (o_head_handle),
        .o_got_valid   (o_got_valid),
        .o_got_handle  (o_got_handle)
    );

endmodule

`default_nettype wire

// ===== rtl/core/drr_checker.sv =====
// Port-level checker for the descriptor ring recycler, bound to the top level.
`default_nettype none
`include "descriptor_ring_recycler_core_assert.svh"

module drr_checker
    import drr_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [CNT_W-1:0]    o_rx_count,
    input wire logic                o_head_valid,
    input wire logic [LEN_W-1:0]    o_head_len,
    input wire logic [TIME_W-1:0]   o_head_time,
    input wire logic [HANDLE_W-1:0] o_head_handle,
    input wire logic                o_got_valid,
    input wire logic [HANDLE_W-1:0] o_got_handle
);

    // A stalled result word holds.
    `DRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_status) && $stable(o_rx_count) && $stable(o_got_handle))

    // The head flag agrees with the rx count.
    `DRR_ASSERT_NOW(a_head_cnt, i_clk, i_rst_n, o_valid,
        (o_rx_count != '0) == o_head_valid)

    // Head fields are zero when the rx ring is empty.
    `DRR_ASSERT_NOW(a_head_zero, i_clk, i_rst_n, o_valid && !o_head_valid,
        (o_head_len == '0) && (o_head_time == '0) && (o_head_handle == '0))

    // A released handle comes only with an ok status, and is zero otherwise.
    `DRR_ASSERT_NOW(a_got_ok, i_clk, i_rst_n, o_valid && o_got_valid, o_status == ST_OK)
    `DRR_ASSERT_NOW(a_got_zero, i_clk, i_rst_n, o_valid && !o_got_valid, o_got_handle == '0)

endmodule

bind descriptor_ring_recycler_core drr_checker u_drr_checker (.*);

`default_nettype wire
